// ===== sv/dcc_bit_waveform_sender_top_assert.svh =====
// assertion macros for the dcc bit waveform sender checker
// expects signals clk and rst_n in the scope where a macro is used
`ifndef DCC_BIT_WAVEFORM_SENDER_TOP_ASSERT_SVH
`define DCC_BIT_WAVEFORM_SENDER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dcc_pkg.sv =====
// shared types and constants for the dcc bit waveform sender
// no dependencies
package dcc_pkg;

    // sending phase of the line driver
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PRE  = 2'd1,
        PH_HIGH = 2'd2,
        PH_LOW  = 2'd3
    } phase_t;

    // input word kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_ONE_HALF  = 2'd0,
        REG_ZERO_HALF = 2'd1,
        REG_PREAMBLE  = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_idx_t;

    localparam int CFG_W    = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;
    localparam int MSG_W    = 64;
    localparam int BCNT_W   = 7;

    localparam logic [CFG_W-1:0] ONE_HALF_RST  = 16'd58;
    localparam logic [CFG_W-1:0] ZERO_HALF_RST = 16'd100;
    localparam logic [CFG_W-1:0] PREAMBLE_RST  = 16'd500;

endpackage

// ===== sv/dcc_bit_waveform_sender_top.sv =====
// dcc bit waveform sender: pulse waveform generator for one output line
// depends on dcc_pkg
//
// usage
// - input channel (in_valid/in_ready) carries one word per tick or start:
//   kind = 0 advances time by one tick, kind = 1 loads message and bit_count
//   and starts a frame (preamble low, then bits msb first, then final high)
// - output channel (out_valid/out_ready) returns exactly one result word per
//   input word: line_level, busy_res, start_rejected, frame_done
// - the result is registered: the result of a word accepted at a clock edge is
//   shown from that edge on and held until taken
// - throughput is one word per cycle while results are taken; the state
//   update is a single pass (one counter decrement, one shift, one compare)
//   from the state registers to the result register
// - in_ready stays high while the result register is empty or being taken;
//   while a result word waits on a stalled receiver, in_ready is low and no
//   further word is taken
// - a start while busy is dropped and flagged by start_rejected
// - apb port: one_half_ticks at 0x0, zero_half_ticks at 0x4,
//   preamble_ticks at 0x8; pready is tied high; write only while idle
// - reset clears the phase to idle, the line to low, the result register
//   to empty and the registers to 58 / 100 / 500
module dcc_bit_waveform_sender_top
    import dcc_pkg::*;
#(
    parameter int MAX_BITS    = 64,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input words
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [MSG_W-1:0]     message,
    input  logic [BCNT_W-1:0]    bit_count,
    // result words
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 line_level,
    output logic                 busy_res,
    output logic                 start_rejected,
    output logic                 frame_done,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int BL_W = $clog2(MAX_BITS + 1);
    localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

    // configuration registers
    logic [CFG_W-1:0] one_half_reg;
    logic [CFG_W-1:0] zero_half_reg;
    logic [CFG_W-1:0] preamble_reg;

    // sender state
    phase_t                 phase_reg,  phase_next;
    logic [MAX_BITS-1:0]    shift_reg,  shift_next;
    logic [BL_W-1:0]        bits_reg,   bits_next;
    logic [COUNT_WIDTH-1:0] tc_reg,     tc_next;
    logic [COUNT_WIDTH-1:0] half_reg,   half_next;
    logic                   level_reg,  level_next;

    // result register
    logic out_valid_reg;
    logic line_level_reg, line_level_next;
    logic busy_reg,       busy_next;
    logic rejected_reg,   rejected_next;
    logic done_reg,       done_next;

    logic                   accept;
    logic                   cfg_wr;
    reg_idx_t               cfg_idx;
    logic [COUNT_WIDTH-1:0] fit_one;
    logic [COUNT_WIDTH-1:0] fit_zero;
    logic [COUNT_WIDTH-1:0] fit_pre;
    logic [COUNT_WIDTH-1:0] tc_dec;
    logic                   seg_end;

    // duration fit: zero counts as one tick, larger than the counter saturates
    function automatic logic [COUNT_WIDTH-1:0] fit_count(input logic [CFG_W-1:0] v);
        logic [31:0] w;
        w = {{(32-CFG_W){1'b0}}, v};
        if (w == 32'd0)
            w = 32'd1;
        else if (w > CNT_MAX)
            w = CNT_MAX;
        return w[COUNT_WIDTH-1:0];
    endfunction

    assign fit_one  = fit_count(one_half_reg);
    assign fit_zero = fit_count(zero_half_reg);
    assign fit_pre  = fit_count(preamble_reg);

    // handshakes: the result register frees up in the cycle it is taken
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // tick countdown, floored at zero
    assign tc_dec  = (tc_reg != '0) ? tc_reg - COUNT_WIDTH'(1) : '0;
    assign seg_end = (tc_dec == '0);

    // ---------------------------------------------------------------
    // register port
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_ONE_HALF:  prdata = {{(APB_DW-CFG_W){1'b0}}, one_half_reg};
            REG_ZERO_HALF: prdata = {{(APB_DW-CFG_W){1'b0}}, zero_half_reg};
            REG_PREAMBLE:  prdata = {{(APB_DW-CFG_W){1'b0}}, preamble_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_half_reg  <= ONE_HALF_RST;
            zero_half_reg <= ZERO_HALF_RST;
            preamble_reg  <= PREAMBLE_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ONE_HALF:  one_half_reg  <= pwdata[CFG_W-1:0];
                REG_ZERO_HALF: zero_half_reg <= pwdata[CFG_W-1:0];
                REG_PREAMBLE:  preamble_reg  <= pwdata[CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // next state of the sender for the word at the input
    // ---------------------------------------------------------------
    always_comb
    begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        tc_next    = tc_reg;
        half_next  = half_reg;
        level_next = level_reg;

        if (kind == KIND_START)
        begin
            // a start while busy leaves everything as is
            if (phase_reg == PH_IDLE)
            begin
                shift_next = message[MSG_W-1 -: MAX_BITS];
                if (32'(bit_count) > 32'(MAX_BITS))
                    bits_next = BL_W'(MAX_BITS);
                else
                    bits_next = BL_W'(bit_count);
                level_next = 1'b0;
                phase_next = PH_PRE;
                tc_next    = fit_pre;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            tc_next = tc_dec;
            if (seg_end)
            begin
                if (phase_reg == PH_HIGH)
                begin
                    // second half of the bit
                    level_next = 1'b0;
                    phase_next = PH_LOW;
                    tc_next    = half_reg;
                end
                else if (bits_reg == '0)
                begin
                    // final high level, frame ends
                    level_next = 1'b1;
                    phase_next = PH_IDLE;
                    tc_next    = '0;
                end
                else
                begin
                    // next bit, msb first
                    half_next  = shift_reg[MAX_BITS-1] ? fit_one : fit_zero;
                    tc_next    = shift_reg[MAX_BITS-1] ? fit_one : fit_zero;
                    shift_next = {shift_reg[MAX_BITS-2:0], 1'b0};
                    bits_next  = bits_reg - BL_W'(1);
                    level_next = 1'b1;
                    phase_next = PH_HIGH;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result word for the word at the input
    // ---------------------------------------------------------------
    always_comb
    begin
        line_level_next = level_next;
        busy_next       = (phase_next != PH_IDLE);
        rejected_next   = (kind == KIND_START) && (phase_reg != PH_IDLE);
        done_next       = (kind == KIND_TICK) && (phase_reg != PH_IDLE) && seg_end
                          && (phase_reg != PH_HIGH) && (bits_reg == '0);
    end

    // state advances only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            shift_reg <= '0;
            bits_reg  <= '0;
            tc_reg    <= '0;
            half_reg  <= '0;
            level_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            tc_reg    <= tc_next;
            half_reg  <= half_next;
            level_reg <= level_next;
        end
    end

    // result register: loads on accept, empties when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_level_reg <= line_level_next;
            busy_reg       <= busy_next;
            rejected_reg   <= rejected_next;
            done_reg       <= done_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign line_level     = line_level_reg;
    assign busy_res       = busy_reg;
    assign start_rejected = rejected_reg;
    assign frame_done     = done_reg;

endmodule

// ===== sv/dcc_checker.sv =====
// port-level checker for the dcc bit waveform sender, bound to the top level
// depends on dcc_bit_waveform_sender_top_assert.svh
`include "dcc_bit_waveform_sender_top_assert.svh"

module dcc_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic line_level,
    input logic busy_res,
    input logic start_rejected,
    input logic frame_done
);

    // a stalled result word holds
    `DCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({line_level, busy_res, start_rejected, frame_done}), "result word changed while stalled")

    // every accepted word gives a result word in the next cycle
    `DCC_ASSERT_NEXT(a_in_to_out, in_valid && in_ready, out_valid, "accepted word gave no result word")

    // a rejected start only happens while a frame is running
    `DCC_ASSERT_NOW(a_reject_busy, out_valid && start_rejected, busy_res && !frame_done, "start rejected while not busy")

    // the frame ends with the line high and the sender idle
    `DCC_ASSERT_NOW(a_done_level, out_valid && frame_done, line_level && !busy_res, "frame end without final high level")

endmodule

bind dcc_bit_waveform_sender_top dcc_checker u_dcc_checker (.*);

// ===== verif/dcc_bit_waveform_sender_top_tb.sv =====
// self-checking testbench for dcc_bit_waveform_sender_top: directed table, then random
// frames under many timing settings, with results predicted and checked word by word
// depends on dcc_pkg and dcc_bit_waveform_sender_top
`timescale 1ns / 1ps

module dcc_bit_waveform_sender_top_tb;
    import dcc_pkg::*;

    // frame length cap, matches the block's default
    localparam int MAX_BITS = 64;
    // meaningful words wanted from the random part
    localparam int RANDOM_WORDS = 1500;

    // one result word, field order matches the typed rows below
    typedef struct packed {
        logic line;
        logic busy;
        logic rej;
        logic done;
    } line_res_t;

    // one directed row; res is only used when typed is set
    typedef struct packed {
        logic               k;
        logic [MSG_W-1:0]   msg;
        logic [BCNT_W-1:0]  cnt;
        logic               typed;
        line_res_t          res;
    } stim_row_t;

    localparam int DIR_ROWS = 19;

    // directed sequence, run with one_half = 1, zero_half = 2, preamble = 0 (one tick)
    // res = {line_level, busy_res, start_rejected, frame_done}
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        // tick while idle right after reset: nothing moves, line still low
        '{KIND_TICK,  64'h0,                  7'd0,   1'b1, 4'b0000},
        // empty frame starts: line pulled low, busy
        '{KIND_START, 64'h0,                  7'd0,   1'b1, 4'b0100},
        // start while busy: dropped and flagged
        '{KIND_START, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b1, 4'b0110},
        // one preamble tick, no bits: final high at once
        '{KIND_TICK,  64'h0,                  7'd0,   1'b1, 4'b1001},
        // tick while idle after a frame: line stays high
        '{KIND_TICK,  64'h0,                  7'd0,   1'b1, 4'b1000},
        // two bits, one then zero
        '{KIND_START, 64'hA000_0000_0000_0000, 7'd2,   1'b0, 4'b0000},
        '{KIND_TICK,  64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b0, 4'b0000},
        '{KIND_TICK,  64'h0,                  7'd0,   1'b0, 4'b0000},
        '{KIND_TICK,  64'h0,                  7'd0,   1'b0, 4'b0000},
        '{KIND_TICK,  64'h0,                  7'd0,   1'b0, 4'b0000},
        '{KIND_TICK,  64'h0,                  7'd0,   1'b0, 4'b0000},
        '{KIND_TICK,  64'h0,                  7'd0,   1'b0, 4'b0000},
        '{KIND_TICK,  64'h0,                  7'd0,   1'b0, 4'b0000},
        '{KIND_TICK,  64'h0,                  7'd0,   1'b0, 4'b0000},
        // oversized bit count saturates to the full 64 bits
        '{KIND_START, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b0, 4'b0000},
        '{KIND_TICK,  64'h0,                  7'd0,   1'b0, 4'b0000},
        // largest legal count, but the sender is busy
        '{KIND_START, 64'h0,                  7'd64,  1'b0, 4'b0000},
        '{KIND_TICK,  64'h0,                  7'd0,   1'b0, 4'b0000},
        '{KIND_TICK,  64'h0,                  7'd0,   1'b0, 4'b0000}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 kind;
    logic [MSG_W-1:0]     message;
    logic [BCNT_W-1:0]    bit_count;
    logic                 out_valid;
    logic                 out_ready;
    logic                 line_level;
    logic                 busy_res;
    logic                 start_rejected;
    logic                 frame_done;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    dcc_bit_waveform_sender_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .message        (message),
        .bit_count      (bit_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .line_level     (line_level),
        .busy_res       (busy_res),
        .start_rejected (start_rejected),
        .frame_done     (frame_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copies of the timing registers, loaded with the reset values
    logic [CFG_W-1:0]  one_half_sh  = ONE_HALF_RST;
    logic [CFG_W-1:0]  zero_half_sh = ZERO_HALF_RST;
    logic [CFG_W-1:0]  preamble_sh  = PREAMBLE_RST;

    // encoder state as the block should hold it
    logic [MSG_W-1:0]  pending_bits = '0;
    logic [BCNT_W-1:0] bits_to_send = '0;
    phase_t            enc_phase    = PH_IDLE;
    logic [CFG_W-1:0]  ticks_left   = '0;
    logic [CFG_W-1:0]  half_ticks   = '0;
    logic              line_now     = 1'b0;

    // result words still to come, oldest first
    line_res_t         expected_levels[$];

    int                mismatches   = 0;
    // words that moved the encoder (accepted starts, ticks while busy)
    int                active_words = 0;
    // sender burst pacing
    int                burst_left   = 0;

    // a zero duration counts as one tick; 16-bit registers always fit the counter
    function automatic logic [CFG_W-1:0] clamp_ticks(input logic [CFG_W-1:0] v);
        return (v == '0) ? CFG_W'(1) : v;
    endfunction

    // advance the expected encoder state by one word and give the result it causes
    task automatic advance_encoder(input logic k, input logic [MSG_W-1:0] msg,
                                   input logic [BCNT_W-1:0] cnt, output line_res_t r);
        logic rej;
        logic done;
        rej  = 1'b0;
        done = 1'b0;
        if (k == KIND_START)
        begin
            if (enc_phase != PH_IDLE)
                rej = 1'b1;
            else
            begin
                pending_bits = msg;
                bits_to_send = (cnt > MAX_BITS) ? BCNT_W'(MAX_BITS) : cnt;
                line_now     = 1'b0;
                enc_phase    = PH_PRE;
                ticks_left   = clamp_ticks(preamble_sh);
            end
        end
        else if (enc_phase != PH_IDLE)
        begin
            if (ticks_left != '0)
                ticks_left = ticks_left - 1'b1;
            if (ticks_left == '0)
            begin
                if (enc_phase == PH_HIGH)
                begin
                    // second half of the same bit
                    line_now   = 1'b0;
                    enc_phase  = PH_LOW;
                    ticks_left = half_ticks;
                end
                else if (bits_to_send == '0)
                begin
                    // last segment over: final high level, frame ends
                    line_now   = 1'b1;
                    enc_phase  = PH_IDLE;
                    ticks_left = '0;
                    done       = 1'b1;
                end
                else
                begin
                    // next bit, msb first
                    half_ticks   = clamp_ticks(pending_bits[MSG_W-1] ? one_half_sh
                                                                     : zero_half_sh);
                    pending_bits = pending_bits << 1;
                    bits_to_send = bits_to_send - 1'b1;
                    line_now     = 1'b1;
                    enc_phase    = PH_HIGH;
                    ticks_left   = half_ticks;
                end
            end
        end
        r.line = line_now;
        r.busy = (enc_phase != PH_IDLE);
        r.rej  = rej;
        r.done = done;
    endtask

    // sender pacing: bursts of random length, random gaps between them,
    // now and then a long burst with no gap at all
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(100, 400);
            else
                burst_left = $urandom_range(1, 20);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
    endtask

    // offer one word at a falling edge, hold it until taken, queue its result;
    // returns at the next falling edge with valid still high
    task automatic send_word(input logic k, input logic [MSG_W-1:0] msg,
                             input logic [BCNT_W-1:0] cnt, input logic typed,
                             input line_res_t typed_res);
        line_res_t r;
        pace_sender();
        in_valid  <= 1'b1;
        kind      <= k;
        message   <= msg;
        bit_count <= cnt;
        do
            @(posedge clk);
        while (!in_ready);
        if ((k == KIND_START) == (enc_phase == PH_IDLE))
            active_words++;
        advance_encoder(k, msg, cnt, r);
        expected_levels.push_back(typed ? typed_res : r);
        @(negedge clk);
    endtask

    // tick until the running frame has ended, random don't-care payload
    task automatic finish_frame();
        while (enc_phase != PH_IDLE)
            send_word(KIND_TICK, {$urandom, $urandom}, BCNT_W'($urandom), 1'b0, '0);
    endtask

    // stop offering words and wait until every result has been taken
    task automatic wait_all_taken();
        in_valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // one register transfer: setup cycle, access cycle, done when pready is seen
    task automatic cfg_access(input logic wr, input reg_idx_t idx,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write a timing register; only the low 16 bits of the data are kept
    task automatic cfg_write(input reg_idx_t idx, input logic [APB_DW-1:0] wdata);
        logic [APB_DW-1:0] ignored;
        cfg_access(1'b1, idx, wdata, ignored);
        case (idx)
            REG_ONE_HALF:  one_half_sh  = wdata[CFG_W-1:0];
            REG_ZERO_HALF: zero_half_sh = wdata[CFG_W-1:0];
            REG_PREAMBLE:  preamble_sh  = wdata[CFG_W-1:0];
            default: ;
        endcase
    endtask

    // read back all three timing registers against the shadows
    task automatic cfg_readback();
        reg_idx_t           idx;
        logic [APB_DW-1:0]  got;
        logic [APB_DW-1:0]  want;
        for (int i = 0; i < 3; i++)
        begin
            idx = reg_idx_t'(i);
            case (idx)
                REG_ONE_HALF:  want = APB_DW'(one_half_sh);
                REG_ZERO_HALF: want = APB_DW'(zero_half_sh);
                default:       want = APB_DW'(preamble_sh);
            endcase
            cfg_access(1'b0, idx, '0, got);
            if (got !== want)
            begin
                mismatches++;
                $error("%s: expected %0d, got %0d", idx.name(), want, got);
            end
        end
    endtask

    // result checker: every taken word against the oldest expectation
    always @(posedge clk)
    begin : result_check
        line_res_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_levels.size() == 0)
            begin
                mismatches++;
                $error("unexpected result word: line_level=%0b busy_res=%0b %s=%0b %s=%0b",
                       line_level, busy_res, "start_rejected", start_rejected,
                       "frame_done", frame_done);
            end
            else
            begin
                want = expected_levels.pop_front();
                if (line_level !== want.line)
                begin
                    mismatches++;
                    $error("line_level: expected %0b, got %0b", want.line, line_level);
                end
                if (busy_res !== want.busy)
                begin
                    mismatches++;
                    $error("busy_res: expected %0b, got %0b", want.busy, busy_res);
                end
                if (start_rejected !== want.rej)
                begin
                    mismatches++;
                    $error("start_rejected: expected %0b, got %0b", want.rej, start_rejected);
                end
                if (frame_done !== want.done)
                begin
                    mismatches++;
                    $error("frame_done: expected %0b, got %0b", want.done, frame_done);
                end
            end
        end
    end

    // receiver: runs of always ready, coin flips, light and heavy stalling
    initial
    begin : receiver
        int mode;
        int run_left;
        int pick;
        out_ready = 1'b0;
        mode      = 0;
        run_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (run_left == 0)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 7)
                    mode = 0;
                else if (pick < 12)
                    mode = 1;
                else if (pick < 18)
                    mode = 2;
                else
                    mode = 3;
                run_left = $urandom_range(4, 60);
            end
            run_left--;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 1) == 1);
                2:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // main sequence
    initial
    begin : stimulus
        int                 goal;
        int                 n_words;
        int                 pick;
        int                 reg_mask;
        logic               k;
        logic [MSG_W-1:0]   msg;
        logic [BCNT_W-1:0]  cnt;
        logic [CFG_W-1:0]   upper;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_TICK;
        message   = '0;
        bit_count = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values of the timing registers
        cfg_readback();

        // short timings for the directed table; preamble zero acts as one tick,
        // upper data bits are dropped
        cfg_write(REG_ONE_HALF, 32'd1);
        cfg_write(REG_ZERO_HALF, 32'd2);
        cfg_write(REG_PREAMBLE, 32'hFFFF_0000);
        cfg_readback();

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(DIRECTED[i].k, DIRECTED[i].msg, DIRECTED[i].cnt,
                      DIRECTED[i].typed, DIRECTED[i].res);
        finish_frame();
        wait_all_taken();

        // random part: short timings so that many whole frames fit,
        // new settings between phases, block idle and drained before each write
        goal = active_words + RANDOM_WORDS;
        while (active_words < goal)
        begin
            reg_mask = $urandom_range(1, 7);
            upper    = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom) : '0;
            if (reg_mask[0])
                cfg_write(REG_ONE_HALF, {upper, ($urandom_range(0, 9) == 0) ? CFG_W'(0)
                                                : CFG_W'($urandom_range(1, 4))});
            if (reg_mask[1])
                cfg_write(REG_ZERO_HALF, {upper, ($urandom_range(0, 9) == 0) ? CFG_W'(0)
                                                 : CFG_W'($urandom_range(1, 5))});
            if (reg_mask[2])
                cfg_write(REG_PREAMBLE, {upper, CFG_W'($urandom_range(0, 12))});
            cfg_readback();

            n_words = $urandom_range(60, 220);
            repeat (n_words)
            begin
                // mostly well-formed frames: start when idle, tick when busy,
                // with some idle ticks and starts while busy mixed in
                if (enc_phase == PH_IDLE)
                    k = ($urandom_range(0, 4) != 0) ? KIND_START : KIND_TICK;
                else
                    k = ($urandom_range(0, 24) == 0) ? KIND_START : KIND_TICK;
                msg  = {$urandom, $urandom};
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    cnt = BCNT_W'($urandom_range(0, 12));
                else if (pick == 7)
                    cnt = BCNT_W'($urandom_range(13, 64));
                else if (pick == 8)
                    cnt = BCNT_W'(MAX_BITS);
                else
                    cnt = BCNT_W'($urandom_range(65, 127));
                send_word(k, msg, cnt, 1'b0, '0);
            end
            finish_frame();
            // hold the sender until every result is back
            wait_all_taken();
        end

        // widest register values read back
        cfg_write(REG_ONE_HALF, 32'h0000_FFFF);
        cfg_write(REG_ZERO_HALF, 32'h0000_FFFF);
        cfg_write(REG_PREAMBLE, 32'hFFFF_FFFF);
        cfg_readback();

        // long preamble and one-bit half, zero-bit half written as zero
        cfg_write(REG_ONE_HALF, 32'd48);
        cfg_write(REG_ZERO_HALF, 32'd0);
        cfg_write(REG_PREAMBLE, 32'd64);
        cfg_readback();
        send_word(KIND_START, {2'b10, 62'($urandom)}, 7'd2, 1'b0, '0);
        finish_frame();
        wait_all_taken();

        // long zero-bit half, shortest legal others
        cfg_write(REG_ONE_HALF, 32'd1);
        cfg_write(REG_ZERO_HALF, 32'd80);
        cfg_write(REG_PREAMBLE, 32'd1);
        cfg_readback();
        send_word(KIND_START, {1'b0, 63'({$urandom, $urandom})}, 7'd1, 1'b0, '0);
        finish_frame();
        wait_all_taken();

        // wait out any stray result word
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin : watchdog
        #400_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
